/* sv/handle_pool_allocator_defines.svh */
// Assertion macros shared by the handle pool allocator modules.
`ifndef HANDLE_POOL_ALLOCATOR_DEFINES_SVH
`define HANDLE_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/hpa_pkg.sv */
// Types and constants of the handle pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package hpa_pkg;

    localparam int HANDLE_W = 6;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_TRY   = 2'd1,
        MODE_FREE  = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREED  = 2'd1,
        STAT_EXHAUSTED = 2'd2,
        STAT_NOT_ALLOC = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic pop;
        logic push;
    } queue_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

`default_nettype wire

/* sv/hpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/hpa_free_queue.sv */
// First-in-first-out queue of released handles, held in a RAM.
`timescale 1ns / 1ps
`default_nettype none

`include "handle_pool_allocator_defines.svh"

module hpa_free_queue #(
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire hpa_pkg::queue_ctl_t      ctl,
    input  wire logic [$clog2(DEPTH)-1:0] push_data,
    output logic      [$clog2(DEPTH)-1:0] head_data,
    output hpa_pkg::queue_stat_t          stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.pop)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (ctl.push)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (ctl.push && !ctl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop && !ctl.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));

    hpa_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.push),
        .waddr (tail_reg),
        .wdata (push_data),
        .re    (ctl.rd_en),
        .raddr (head_reg),
        .rdata (head_data)
    );

    `HPA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "queue count beyond depth")
    `HPA_ASSERT_NOW(a_no_pop_empty, ctl.pop, !stat.empty, "pop from empty queue")
    `HPA_ASSERT_NOW(a_no_push_full, ctl.push, !stat.full, "push to full queue")

endmodule

`default_nettype wire

/* sv/handle_pool_allocator.sv */
// Top level of the handle pool allocator.
//
// Input channel (in_valid / in_stall) carries one request word: mode and
// handle_in. Output channel (out_valid / out_stall) returns one word per
// request: handle_out and status.
// A request is accepted only in the idle state; its result is registered when
// the work state fires with the result register free. One request is worked
// at a time, so no new word is taken until the last one is worked. Work is a
// read of the free queue and allocation bitmap RAMs, then a read-modify-write.
// in_stall is high while a request is in work. The result register holds its
// word while out_stall is high; a request accepted meanwhile waits in the
// work cycle until the result register is free.
// Reset clears the queue pointers, the fresh-handle counter, the control state
// and the output valid. The bitmap needs no clearing pass: entries at or above
// the fresh-handle counter read as not allocated. No handle at or above POOL_SIZE
// is issued; allocate then reports the pool exhausted.
`timescale 1ns / 1ps
`default_nettype none

`include "handle_pool_allocator_defines.svh"

module handle_pool_allocator #(
    parameter int POOL_SIZE = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [hpa_pkg::MODE_W-1:0]     mode,
    input  wire logic [hpa_pkg::HANDLE_W-1:0]   handle_in,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [hpa_pkg::HANDLE_W-1:0]   handle_out,
    output logic      [hpa_pkg::STATUS_W-1:0]   status
);

    localparam int AW = $clog2(POOL_SIZE);
    localparam int XW = ((AW > hpa_pkg::HANDLE_W) ? AW : hpa_pkg::HANDLE_W) + 1;

    hpa_pkg::state_t state_reg, state_next;

    logic [hpa_pkg::MODE_W-1:0]   mode_reg;
    logic [hpa_pkg::HANDLE_W-1:0] hin_reg;
    logic [AW:0]                  fresh_reg, fresh_next;

    logic                         out_valid_reg, out_valid_next;
    logic [hpa_pkg::HANDLE_W-1:0] handle_out_reg, handle_out_next;
    logic [hpa_pkg::STATUS_W-1:0] status_reg, status_next;

    hpa_pkg::queue_ctl_t  q_ctl;
    hpa_pkg::queue_stat_t q_stat;
    logic [AW-1:0]        q_head;

    logic          map_we;
    logic [AW-1:0] map_waddr;
    logic          map_wdata;
    logic          map_rdata;

    logic          accept;
    logic          slot_free;
    logic          fire;
    logic [XW-1:0] hin_in_x;
    logic [XW-1:0] hin_x;
    logic [AW-1:0] hin_addr;
    logic          hin_range;
    logic          hin_alloc;
    logic [AW-1:0] grant;
    logic [XW-1:0] grant_x;

    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign fire      = (state_reg == hpa_pkg::ST_EXEC) && slot_free;

    assign hin_in_x  = XW'(handle_in);
    assign hin_x     = XW'(hin_reg);
    assign hin_addr  = hin_x[AW-1:0];
    assign hin_range = hin_x < XW'(POOL_SIZE);
    assign hin_alloc = hin_range && ({1'b0, hin_addr} < fresh_reg) && map_rdata;
    assign grant_x   = XW'(grant);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpa_pkg::ST_IDLE;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            hin_reg  <= handle_in;
        end
        handle_out_reg <= handle_out_next;
        status_reg     <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        fresh_next      = fresh_reg;
        out_valid_next  = out_valid_reg && out_stall;
        handle_out_next = handle_out_reg;
        status_next     = status_reg;
        q_ctl.rd_en     = accept;
        q_ctl.pop       = 1'b0;
        q_ctl.push      = 1'b0;
        map_we          = 1'b0;
        map_waddr       = q_head;
        map_wdata       = 1'b1;
        grant           = '0;
        in_stall        = (state_reg != hpa_pkg::ST_IDLE);

        case (state_reg)
            hpa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = hpa_pkg::ST_EXEC;
                end
            end
            hpa_pkg::ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = hpa_pkg::ST_IDLE;
                    status_next = hpa_pkg::STAT_OK;
                    case (hpa_pkg::mode_t'(mode_reg))
                        hpa_pkg::MODE_ALLOC:
                        begin
                            if (!q_stat.empty)
                            begin
                                q_ctl.pop = 1'b1;
                                grant     = q_head;
                                map_we    = 1'b1;
                            end
                            else if (fresh_reg == (AW + 1)'(POOL_SIZE))
                            begin
                                status_next = hpa_pkg::STAT_EXHAUSTED;
                            end
                            else
                            begin
                                grant      = fresh_reg[AW-1:0];
                                map_we     = 1'b1;
                                map_waddr  = fresh_reg[AW-1:0];
                                fresh_next = fresh_reg + 1'b1;
                            end
                        end
                        hpa_pkg::MODE_TRY:
                        begin
                            if (!q_stat.empty)
                            begin
                                q_ctl.pop = 1'b1;
                                grant     = q_head;
                                map_we    = 1'b1;
                            end
                            else
                            begin
                                status_next = hpa_pkg::STAT_NO_FREED;
                            end
                        end
                        hpa_pkg::MODE_FREE:
                        begin
                            if (hin_alloc && !q_stat.full)
                            begin
                                q_ctl.push = 1'b1;
                                map_we     = 1'b1;
                                map_waddr  = hin_addr;
                                map_wdata  = 1'b0;
                            end
                            else
                            begin
                                status_next = hpa_pkg::STAT_NOT_ALLOC;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    out_valid_next  = 1'b1;
                    handle_out_next = grant_x[hpa_pkg::HANDLE_W-1:0];
                end
            end
            default:
            begin
                state_next = hpa_pkg::ST_IDLE;
            end
        endcase
    end

    hpa_free_queue #(
        .DEPTH (POOL_SIZE)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (q_ctl),
        .push_data (hin_addr),
        .head_data (q_head),
        .stat      (q_stat)
    );

    hpa_ram #(
        .WIDTH (1),
        .DEPTH (POOL_SIZE)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (accept),
        .raddr (hin_in_x[AW-1:0]),
        .rdata (map_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign handle_out = handle_out_reg;
    assign status     = status_reg;

    `HPA_ASSERT_NOW(a_err_zero, out_valid && (status != hpa_pkg::STAT_OK), handle_out == '0, "error word carries a handle")
    `HPA_ASSERT_NEXT(a_accept_exec, accept, state_reg == hpa_pkg::ST_EXEC, "accepted word not worked")
    `HPA_ASSERT_NOW(a_fresh_bound, 1'b1, fresh_reg <= (AW + 1)'(POOL_SIZE), "fresh handle beyond pool")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench of the handle pool allocator: directed and random requests.
`timescale 1ns / 1ps

module tb_top;

    import hpa_pkg::*;

    localparam int           POOL        = 64;
    localparam logic [1:0]   MODE_UNUSED = 2'd3;
    localparam int           MAX_LINES   = 100;

    typedef struct {
        logic [HANDLE_W-1:0] handle;
        status_t             stat;
    } grant_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] handle_in;
    logic                out_valid;
    logic                out_stall;
    logic [HANDLE_W-1:0] handle_out;
    logic [STATUS_W-1:0] status;

    // predictor state
    logic [HANDLE_W-1:0] freed_q[$];
    logic [POOL-1:0]     held_map;
    int unsigned         fresh_next;

    grant_t              grant_q[$];
    int                  errors;
    int                  tx_idle_pct;
    int                  rx_idle_pct;
    int                  hold_left;

    handle_pool_allocator #(.POOL_SIZE(POOL)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .handle_in  (handle_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .handle_out (handle_out),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (errors < MAX_LINES)
            $display("%0t ns: %s", $time, what);
        errors++;
    endtask

    function automatic grant_t predict_grant(input logic [1:0] m, input logic [HANDLE_W-1:0] h);
        grant_t g;
        g.handle = '0;
        g.stat   = STAT_OK;
        case (m)
            MODE_ALLOC:
            begin
                if (freed_q.size() > 0)
                begin
                    g.handle = freed_q.pop_front();
                    held_map[g.handle] = 1'b1;
                end
                else if (fresh_next >= POOL)
                    g.stat = STAT_EXHAUSTED;
                else
                begin
                    g.handle = fresh_next[HANDLE_W-1:0];
                    held_map[g.handle] = 1'b1;
                    fresh_next++;
                end
            end
            MODE_TRY:
            begin
                if (freed_q.size() > 0)
                begin
                    g.handle = freed_q.pop_front();
                    held_map[g.handle] = 1'b1;
                end
                else
                    g.stat = STAT_NO_FREED;
            end
            MODE_FREE:
            begin
                if (!held_map[h])
                    g.stat = STAT_NOT_ALLOC;
                else
                begin
                    freed_q.push_back(h);
                    held_map[h] = 1'b0;
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_held();
        logic [HANDLE_W-1:0] live[$];
        for (int i = 0; i < POOL; i++)
            if (held_map[i])
                live.push_back(i[HANDLE_W-1:0]);
        if (live.size() == 0)
            return HANDLE_W'($urandom_range(POOL - 1));
        return live[$urandom_range(live.size() - 1)];
    endfunction

    // one request word, with an optional gap in front
    task automatic send_word(input logic [1:0] m, input logic [HANDLE_W-1:0] h);
        int gap;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        mode      <= m;
        handle_in <= h;
        do
            @(posedge clk);
        while (in_stall);
        grant_q.push_back(predict_grant(m, h));
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        go_idle();
        wait (grant_q.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_directed();
        send_word(MODE_ALLOC, 6'd63);
        send_word(MODE_TRY, 6'd0);
        send_word(MODE_FREE, 6'd63);
        send_word(MODE_FREE, 6'd0);
        send_word(MODE_FREE, 6'd0);
        send_word(MODE_TRY, 6'd63);
        send_word(MODE_ALLOC, 6'd0);
        send_word(MODE_ALLOC, 6'd63);
        send_word(MODE_FREE, 6'd2);
        send_word(MODE_FREE, 6'd1);
        send_word(MODE_ALLOC, 6'd0);
        send_word(MODE_TRY, 6'd0);
        send_word(MODE_TRY, 6'd0);
        send_word(MODE_UNUSED, 6'd63);
        send_word(MODE_UNUSED, 6'd0);
        send_word(MODE_FREE, 6'd3);
        send_word(MODE_FREE, 6'd40);
        send_word(MODE_ALLOC, 6'd21);
        send_word(MODE_FREE, 6'd0);
        send_word(MODE_ALLOC, 6'd42);
    endtask

    task automatic test_exhaustion();
        while (fresh_next < POOL || freed_q.size() > 0)
            send_word(MODE_ALLOC, HANDLE_W'($urandom_range(POOL - 1)));
        send_word(MODE_ALLOC, 6'd63);
        send_word(MODE_ALLOC, 6'd0);
        send_word(MODE_TRY, 6'd63);
        send_word(MODE_FREE, 6'd63);
        send_word(MODE_FREE, 6'd63);
        repeat (6) send_word(MODE_FREE, pick_held());
        send_word(MODE_ALLOC, 6'd0);
        send_word(MODE_TRY, 6'd0);
    endtask

    task automatic test_random(input int count);
        int r;
        int free_w;
        free_w = 40;
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
                free_w = $urandom_range(20, 60);
            r = $urandom_range(99);
            if (r < 4)
                send_word(MODE_UNUSED, HANDLE_W'($urandom_range(POOL - 1)));
            else if (r < 12)
                send_word(MODE_FREE, HANDLE_W'($urandom_range(POOL - 1)));
            else if (r < 22)
                send_word(MODE_TRY, HANDLE_W'($urandom_range(POOL - 1)));
            else if (r < 22 + free_w)
                send_word(MODE_FREE, pick_held());
            else
                send_word(MODE_ALLOC, HANDLE_W'($urandom_range(POOL - 1)));
        end
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        int saved_tx;
        saved_tx    = tx_idle_pct;
        tx_idle_pct = 0;
        @(posedge clk);
        hold_left   = 150;
        test_random(40);
        tx_idle_pct = saved_tx;
    endtask

    task automatic test_drain_pause();
        wait_drained();
        test_random(30);
    endtask

    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        grant_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (grant_q.size() == 0)
                report_mismatch($sformatf("unexpected word: handle %0d status %0d",
                                          handle_out, status));
            else
            begin
                exp_w = grant_q.pop_front();
                if (handle_out !== exp_w.handle)
                    report_mismatch($sformatf("handle_out %0d, want %0d",
                                              handle_out, exp_w.handle));
                if (status !== exp_w.stat)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              status, exp_w.stat));
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_ALLOC;
        handle_in   = '0;
        errors      = 0;
        held_map    = '0;
        fresh_next  = 0;
        hold_left   = 0;
        tx_idle_pct = 8;
        rx_idle_pct = 46;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_exhaustion();
        test_random(500);
        test_backpressure();

        tx_idle_pct = 46;
        rx_idle_pct = 8;
        test_random(500);
        test_drain_pause();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(540);

        go_idle();
        wait (grant_q.size() == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
